[src/tads_pkg.sv]
package tads_pkg;

  localparam int TXN_W      = 6;
  localparam int KEY_HI_W   = 32;
  localparam int KEY_MID_W  = 64;
  localparam int KEY_LO_W   = 64;
  localparam int KEY_W      = KEY_HI_W + KEY_MID_W + KEY_LO_W;
  localparam int EV_W       = 3;
  localparam int TOTAL_W    = TXN_W + 1;
  localparam int INFL_W     = 7;
  localparam logic [INFL_W-1:0] INFLIGHT_MAX = 7'd127;

  localparam int DEF_MAX_TXNS     = 64;
  localparam int DEF_ADDR_ENTRIES = 256;
  localparam int DEF_EDGE_ENTRIES = 1024;

  typedef enum logic [1:0] {
    KIND_TOUCH  = 2'd0,
    KIND_START  = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [EV_W-1:0] {
    EV_DISPATCH  = 3'd0,
    EV_DONE_OK   = 3'd1,
    EV_DONE_FAIL = 3'd2,
    EV_ADDR_FULL = 3'd3,
    EV_EDGE_FULL = 3'd4
  } event_e;

endpackage

[src/txn_address_dependency_scheduler_core.sv]
// Touch: reads and compares each stored address in turn, then stores a new address or adds an
//   edge, then wraps up. Start: reads and checks the degree of each transaction below the touched total.
// Finish with commit fetches its list head and walks each successor edge; else it goes to done.
// Ignored items and clear leave busy low; the next transfer may follow as busy falls.
// Each result is held until the next is found, so the final one can be marked; the last one
//   leaves as busy falls; the receiver cannot stall. Reset and clear empty all tables at once.
module txn_address_dependency_scheduler_core
  import tads_pkg::*;
#(
  parameter int MAX_TXNS     = DEF_MAX_TXNS,
  parameter int ADDR_ENTRIES = DEF_ADDR_ENTRIES,
  parameter int EDGE_ENTRIES = DEF_EDGE_ENTRIES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           kind_i,
  input  logic [TXN_W-1:0]     txn_i,
  input  logic [KEY_HI_W-1:0]  key_hi_i,
  input  logic [KEY_MID_W-1:0] key_mid_i,
  input  logic [KEY_LO_W-1:0]  key_lo_i,
  input  logic                 commit_ok_i,
  output logic                 valid_o,
  output logic [EV_W-1:0]      event_res_o,
  output logic [TXN_W-1:0]     txn_id_o,
  output logic                 last_o
);

  localparam int TW  = $clog2(MAX_TXNS);
  localparam int AW  = $clog2(ADDR_ENTRIES);
  localparam int ACW = $clog2(ADDR_ENTRIES + 1);
  localparam int EW  = $clog2(EDGE_ENTRIES);
  localparam int LW  = $clog2(EDGE_ENTRIES + 1);
  localparam int ATW = KEY_W + TXN_W;
  localparam logic [LW-1:0] EMPTY_LINK = LW'(EDGE_ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE, ST_T_RD, ST_T_CMP, ST_T_MISS, ST_E1, ST_E2, ST_S_RD, ST_S_CMP,
    ST_F_RD, ST_W_H, ST_W_CHK, ST_W_T, ST_W_P, ST_DONE, ST_FIN
  } state_e;

  state_e              state_q;
  logic [TXN_W-1:0]    txn_q, from_q, tg_q;
  logic [KEY_W-1:0]    key_q;
  logic [ACW-1:0]      idx_q, acnt_q;
  logic [LW-1:0]       ecnt_q, cur_q;
  logic [TOTAL_W-1:0]  total_q, i_q;
  logic [INFL_W-1:0]   infl_q;
  logic                fail_q;
  logic [MAX_TXNS-1:0] hv_q, pv_q;
  logic                held_v_q;
  logic [EV_W-1:0]     held_ev_q;
  logic [TXN_W-1:0]    held_id_q;
  logic                out_v_q, out_last_q;
  logic [EV_W-1:0]     out_ev_q;
  logic [TXN_W-1:0]    out_id_q;

  // memory ports
  logic           at_we;
  logic [AW-1:0]  at_waddr;
  logic [ATW-1:0] at_rdata;
  logic           tgt_we, nxt_we;
  logic [EW-1:0]  nxt_waddr;
  logic [LW-1:0]  nxt_wdata;
  logic [TXN_W-1:0] tgt_rdata;
  logic [LW-1:0]  nxt_rdata;
  logic           pd_we;
  logic [TW-1:0]  pd_waddr, pd_raddr;
  logic [LW-1:0]  pd_wdata, pd_rdata;
  logic           hd_we, tl_we;
  logic [LW-1:0]  hd_rdata;
  logic [EW-1:0]  tl_rdata;

  logic             emit;
  logic [EV_W-1:0]  emit_ev;
  logic [TXN_W-1:0] emit_id;
  logic             hit;
  logic [TXN_W-1:0] hit_owner;
  logic [TW-1:0]    pd_sel;
  logic [LW-1:0]    pd_cur, pd_dec;
  logic             pd_zero;
  logic             t_in_range, tg_in_range;

  // index of the degree entry whose read data is on pd_rdata this cycle
  always_comb begin
    case (state_q)
      ST_E2:    pd_sel = TW'(txn_q);
      ST_S_CMP: pd_sel = TW'(i_q);
      default:  pd_sel = TW'(tg_q);
    endcase
  end

  assign hit       = at_rdata[KEY_W-1:0] == key_q;
  assign hit_owner = at_rdata[ATW-1:KEY_W];
  assign pd_cur    = pv_q[pd_sel] ? pd_rdata : '0;
  assign pd_zero   = pd_cur == '0;
  assign pd_dec    = pd_cur - LW'(1);
  assign t_in_range  = 32'(txn_i) < MAX_TXNS;
  assign tg_in_range = 32'(tg_q) < MAX_TXNS;

  always_comb begin
    at_we     = 1'b0;
    at_waddr  = AW'(idx_q);
    tgt_we    = 1'b0;
    nxt_we    = 1'b0;
    nxt_waddr = EW'(ecnt_q);
    nxt_wdata = EMPTY_LINK;
    pd_we     = 1'b0;
    pd_waddr  = TW'(txn_q);
    pd_wdata  = pd_cur + LW'(1);
    pd_raddr  = TW'(txn_q);
    hd_we     = 1'b0;
    tl_we     = 1'b0;
    emit      = 1'b0;
    emit_ev   = EV_DISPATCH;
    emit_id   = '0;
    case (state_q)
      ST_T_CMP: begin
        if (hit) begin
          at_we = 1'b1;
        end
      end
      ST_T_MISS: begin
        if (32'(acnt_q) >= ADDR_ENTRIES) begin
          emit    = 1'b1;
          emit_ev = EV_ADDR_FULL;
        end else begin
          at_we    = 1'b1;
          at_waddr = AW'(acnt_q);
        end
      end
      ST_E1: begin
        tgt_we = 1'b1;
        nxt_we = 1'b1;
      end
      ST_E2: begin
        if (hv_q[TW'(from_q)]) begin
          nxt_we    = 1'b1;
          nxt_waddr = tl_rdata;
          nxt_wdata = ecnt_q;
        end else begin
          hd_we = 1'b1;
        end
        tl_we = 1'b1;
        pd_we = 1'b1;
      end
      ST_S_RD: pd_raddr = TW'(i_q);
      ST_S_CMP: begin
        if (pd_zero) begin
          emit    = 1'b1;
          emit_id = i_q[TXN_W-1:0];
        end
      end
      ST_W_T: pd_raddr = TW'(tgt_rdata);
      ST_W_P: begin
        pd_waddr = TW'(tg_q);
        pd_wdata = pd_dec;
        if (tg_in_range && !pd_zero) begin
          pd_we = 1'b1;
          if (pd_dec == '0) begin
            emit    = 1'b1;
            emit_id = tg_q;
          end
        end
      end
      ST_DONE: begin
        if (infl_q == '0) begin
          emit    = 1'b1;
          emit_ev = fail_q ? EV_DONE_FAIL : EV_DONE_OK;
        end
      end
      default: ;
    endcase
  end

  tads_ram #(.Width(ATW), .Depth(ADDR_ENTRIES)) u_addr_ram (
    .clk_i, .we_i(at_we), .waddr_i(at_waddr), .wdata_i({txn_q, key_q}),
    .raddr_i(AW'(idx_q)), .rdata_o(at_rdata)
  );

  tads_ram #(.Width(TXN_W), .Depth(EDGE_ENTRIES)) u_tgt_ram (
    .clk_i, .we_i(tgt_we), .waddr_i(EW'(ecnt_q)), .wdata_i(txn_q),
    .raddr_i(EW'(cur_q)), .rdata_o(tgt_rdata)
  );

  tads_ram #(.Width(LW), .Depth(EDGE_ENTRIES)) u_nxt_ram (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(nxt_wdata),
    .raddr_i(EW'(cur_q)), .rdata_o(nxt_rdata)
  );

  tads_ram #(.Width(LW), .Depth(MAX_TXNS)) u_pend_ram (
    .clk_i, .we_i(pd_we), .waddr_i(pd_waddr), .wdata_i(pd_wdata),
    .raddr_i(pd_raddr), .rdata_o(pd_rdata)
  );

  tads_ram #(.Width(LW), .Depth(MAX_TXNS)) u_head_ram (
    .clk_i, .we_i(hd_we), .waddr_i(TW'(from_q)), .wdata_i(ecnt_q),
    .raddr_i(TW'(txn_q)), .rdata_o(hd_rdata)
  );

  tads_ram #(.Width(EW), .Depth(MAX_TXNS)) u_tail_ram (
    .clk_i, .we_i(tl_we), .waddr_i(TW'(from_q)), .wdata_i(EW'(ecnt_q)),
    .raddr_i(TW'(from_q)), .rdata_o(tl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      acnt_q     <= '0;
      ecnt_q     <= '0;
      total_q    <= '0;
      infl_q     <= '0;
      fail_q     <= 1'b0;
      hv_q       <= '0;
      pv_q       <= '0;
      held_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      // the held result leaves when a newer one is found or at wrap-up
      out_v_q <= held_v_q && (emit || state_q == ST_FIN);
      if (emit) begin
        if (held_v_q) begin
          out_last_q <= 1'b0;
          out_ev_q   <= held_ev_q;
          out_id_q   <= held_id_q;
        end
        held_v_q  <= 1'b1;
        held_ev_q <= emit_ev;
        held_id_q <= emit_id;
        if (emit_ev == EV_DISPATCH && infl_q < INFLIGHT_MAX) begin
          infl_q <= infl_q + INFL_W'(1);
        end
      end
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            txn_q <= txn_i;
            key_q <= {key_hi_i, key_mid_i, key_lo_i};
            case (kind_i)
              KIND_CLEAR: begin
                acnt_q  <= '0;
                ecnt_q  <= '0;
                total_q <= '0;
                infl_q  <= '0;
                fail_q  <= 1'b0;
                hv_q    <= '0;
                pv_q    <= '0;
              end
              KIND_START: begin
                if (infl_q == '0) begin
                  i_q     <= '0;
                  state_q <= (total_q != '0) ? ST_S_RD : ST_DONE;
                end
              end
              KIND_TOUCH: begin
                if (t_in_range) begin
                  if ({1'b0, txn_i} + TOTAL_W'(1) > total_q) begin
                    total_q <= {1'b0, txn_i} + TOTAL_W'(1);
                  end
                  idx_q   <= '0;
                  state_q <= (acnt_q == '0) ? ST_T_MISS : ST_T_RD;
                end
              end
              default: begin
                if (t_in_range && infl_q != '0) begin
                  infl_q <= infl_q - INFL_W'(1);
                  if (!commit_ok_i) begin
                    fail_q  <= 1'b1;
                    state_q <= ST_DONE;
                  end else begin
                    state_q <= hv_q[TW'(txn_i)] ? ST_F_RD : ST_DONE;
                  end
                end
              end
            endcase
          end
        end
        ST_T_RD: state_q <= ST_T_CMP;
        ST_T_CMP: begin
          if (hit) begin
            from_q <= hit_owner;
            if (hit_owner == txn_q) begin
              state_q <= ST_FIN;
            end else if (32'(ecnt_q) >= EDGE_ENTRIES) begin
              held_v_q  <= 1'b1;
              held_ev_q <= EV_EDGE_FULL;
              held_id_q <= '0;
              state_q   <= ST_FIN;
            end else begin
              state_q <= ST_E1;
            end
          end else if (idx_q + ACW'(1) == acnt_q) begin
            state_q <= ST_T_MISS;
          end else begin
            idx_q   <= idx_q + ACW'(1);
            state_q <= ST_T_RD;
          end
        end
        ST_T_MISS: begin
          if (32'(acnt_q) < ADDR_ENTRIES) begin
            acnt_q <= acnt_q + ACW'(1);
          end
          state_q <= ST_FIN;
        end
        ST_E1: state_q <= ST_E2;
        ST_E2: begin
          hv_q[TW'(from_q)] <= 1'b1;
          pv_q[TW'(txn_q)]  <= 1'b1;
          ecnt_q  <= ecnt_q + LW'(1);
          state_q <= ST_FIN;
        end
        ST_S_RD: state_q <= ST_S_CMP;
        ST_S_CMP: begin
          i_q <= i_q + TOTAL_W'(1);
          if (i_q + TOTAL_W'(1) < total_q && 32'(i_q) + 1 < MAX_TXNS) begin
            state_q <= ST_S_RD;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_F_RD: state_q <= ST_W_H;
        ST_W_H: begin
          cur_q   <= hd_rdata;
          state_q <= ST_W_CHK;
        end
        ST_W_CHK: state_q <= (cur_q >= ecnt_q) ? ST_DONE : ST_W_T;
        ST_W_T: begin
          tg_q    <= tgt_rdata;
          cur_q   <= nxt_rdata;
          state_q <= ST_W_P;
        end
        ST_W_P: state_q <= ST_W_CHK;
        ST_DONE: state_q <= ST_FIN;
        ST_FIN: begin
          if (held_v_q) begin
            out_last_q <= 1'b1;
            out_ev_q   <= held_ev_q;
            out_id_q   <= held_id_q;
            held_v_q   <= 1'b0;
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy        = state_q != ST_IDLE;
  assign valid_o     = out_v_q;
  assign event_res_o = out_ev_q;
  assign txn_id_o    = out_id_q;
  assign last_o      = out_last_q;

endmodule

[src/tads_ram.sv]
module tads_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[src/tads_checker.sv]
module tads_checker
  import tads_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             valid_o,
  input logic [EV_W-1:0]  event_res_o,
  input logic [TXN_W-1:0] txn_id_o,
  input logic             last_o
);

  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && event_res_o != EV_DISPATCH |-> txn_id_o == '0)
    else $error("nonzero txn_id on a non-dispatch event");

  a_ev_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> event_res_o <= EV_EDGE_FULL)
    else $error("event code out of range");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy without an accepted item");

  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy)
    else $error("non-final result while idle");

endmodule

bind txn_address_dependency_scheduler_core tads_checker u_tads_checker (
  .clk_i, .rst_ni, .start, .busy, .valid_o, .event_res_o, .txn_id_o, .last_o
);

[test/txn_address_dependency_scheduler_core_test.sv]
module txn_address_dependency_scheduler_core_test;
  import tads_pkg::*;

  localparam int NTXN   = DEF_MAX_TXNS;
  localparam int NADDR  = DEF_ADDR_ENTRIES;
  localparam int NEDGE  = DEF_EDGE_ENTRIES;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    kind_e              kind;
    logic [TXN_W-1:0]   txn;
    logic [KEY_HI_W-1:0]  hi;
    logic [KEY_MID_W-1:0] mid;
    logic [KEY_LO_W-1:0]  lo;
    logic               ok;
    bit                 drain;
  } sched_item_t;

  typedef struct {
    event_e           ev;
    logic [TXN_W-1:0] id;
    logic             last;
  } sched_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] kind_i = '0;
  logic [TXN_W-1:0] txn_i = '0;
  logic [KEY_HI_W-1:0] key_hi_i = '0;
  logic [KEY_MID_W-1:0] key_mid_i = '0;
  logic [KEY_LO_W-1:0] key_lo_i = '0;
  logic commit_ok_i = 1'b0;
  logic valid_o;
  logic [EV_W-1:0] event_res_o;
  logic [TXN_W-1:0] txn_id_o;
  logic last_o;

  txn_address_dependency_scheduler_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .kind_i(kind_i), .txn_i(txn_i), .key_hi_i(key_hi_i), .key_mid_i(key_mid_i),
    .key_lo_i(key_lo_i), .commit_ok_i(commit_ok_i), .valid_o(valid_o),
    .event_res_o(event_res_o), .txn_id_o(txn_id_o), .last_o(last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sched_item_t  pending_items[$];
  sched_event_t expected_events[$];
  bit failed = 0;
  int cycles = 0;

  // scheduler shadow state
  logic [KEY_LO_W-1:0]  tab_lo[NADDR];
  logic [KEY_MID_W-1:0] tab_mid[NADDR];
  logic [KEY_HI_W-1:0]  tab_hi[NADDR];
  logic [TXN_W-1:0]     tab_owner[NADDR];
  bit   tab_used[NADDR];
  int   tab_count;
  int   degree[NTXN];
  int   succ_first[NTXN];
  int   succ_last[NTXN];
  int   link_target[NEDGE];
  int   link_next[NEDGE];
  int   link_count;
  int   txn_count;
  int   in_flight;
  bit   batch_bad;
  bit   running[NTXN];

  function automatic void clear_schedule();
    for (int i = 0; i < NADDR; i++) tab_used[i] = 0;
    for (int i = 0; i < NTXN; i++) begin
      degree[i] = 0;
      succ_first[i] = NEDGE;
      running[i] = 0;
    end
    tab_count = 0;
    link_count = 0;
    txn_count = 0;
    in_flight = 0;
    batch_bad = 0;
  endfunction

  function automatic void emit(event_e ev, int id);
    sched_event_t r;
    r.ev = ev;
    r.id = id[TXN_W-1:0];
    r.last = 1'b0;
    expected_events = {expected_events, r};
  endfunction

  function automatic void launch_txn(int t);
    emit(EV_DISPATCH, t);
    running[t] = 1;
    if (in_flight < int'(INFLIGHT_MAX)) in_flight++;
  endfunction

  function automatic void check_done();
    if (in_flight == 0) emit(batch_bad ? EV_DONE_FAIL : EV_DONE_OK, 0);
  endfunction

  function automatic void link_txns(int from, int to);
    int e;
    if (link_count >= NEDGE) begin
      emit(EV_EDGE_FULL, 0);
      return;
    end
    e = link_count++;
    link_target[e] = to;
    link_next[e] = NEDGE;
    if (succ_first[from] == NEDGE) succ_first[from] = e;
    else link_next[succ_last[from]] = e;
    succ_last[from] = e;
    degree[to]++;
  endfunction

  function automatic void touch_addr(sched_item_t it);
    int t;
    t = it.txn;
    if (t + 1 > txn_count) txn_count = t + 1;
    for (int i = 0; i < tab_count; i++) begin
      if (tab_used[i] && tab_hi[i] == it.hi && tab_mid[i] == it.mid && tab_lo[i] == it.lo) begin
        if (tab_owner[i] != t) link_txns(tab_owner[i], t);
        tab_owner[i] = t;
        return;
      end
    end
    if (tab_count >= NADDR) begin
      emit(EV_ADDR_FULL, 0);
      return;
    end
    tab_hi[tab_count] = it.hi;
    tab_mid[tab_count] = it.mid;
    tab_lo[tab_count] = it.lo;
    tab_owner[tab_count] = t;
    tab_used[tab_count] = 1;
    tab_count++;
  endfunction

  function automatic void finish_txn(int t, bit ok);
    int e;
    int tg;
    if (in_flight == 0) return;
    in_flight--;
    running[t] = 0;
    if (!ok) batch_bad = 1;
    else begin
      e = succ_first[t];
      for (int steps = 0; e < link_count && steps < link_count; steps++) begin
        tg = link_target[e];
        if (degree[tg] != 0) begin
          degree[tg]--;
          if (degree[tg] == 0) launch_txn(tg);
        end
        e = link_next[e];
      end
    end
    check_done();
  endfunction

  function automatic void schedule_item(sched_item_t it);
    int before_n;
    before_n = expected_events.size();
    case (it.kind)
      KIND_CLEAR: clear_schedule();
      KIND_START: begin
        if (in_flight == 0) begin
          for (int i = 0; i < txn_count && i < NTXN; i++)
            if (degree[i] == 0) launch_txn(i);
          check_done();
        end
      end
      KIND_TOUCH: touch_addr(it);
      default: finish_txn(it.txn, it.ok);
    endcase
    if (expected_events.size() > before_n)
      expected_events[expected_events.size()-1].last = 1'b1;
  endfunction

  // driver
  sched_item_t cur;
  int gap_left = 0;
  int calm_left = 0;
  bit taken;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) schedule_item(cur);
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() != 0 &&
                     (!pending_items[0].drain || expected_events.size() == 0)) begin
          cur = pending_items.pop_front();
          kind_i <= cur.kind;
          txn_i <= cur.txn;
          key_hi_i <= cur.hi;
          key_mid_i <= cur.mid;
          key_lo_i <= cur.lo;
          commit_ok_i <= cur.ok;
          start <= 1'b1;
          if (calm_left > 0) begin
            calm_left--;
            gap_left = 0;
          end else if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(5, 25);
            gap_left = 0;
          end else begin
            gap_left = $urandom_range(0, 18);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  sched_event_t want;
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result: event_res %0d txn_id %0d", event_res_o, txn_id_o);
        failed = 1;
      end else begin
        want = expected_events.pop_front();
        if (event_res_o !== want.ev) begin
          $error("event_res: expected %0d, actual %0d", want.ev, event_res_o);
          failed = 1;
        end
        if (txn_id_o !== want.id) begin
          $error("txn_id: expected %0d, actual %0d", want.id, txn_id_o);
          failed = 1;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last_o);
          failed = 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** txn_address_dependency_scheduler_core: FAILED **");
      $finish;
    end
  end

  // address pool keeps collisions frequent
  logic [KEY_HI_W-1:0]  pool_hi[8];
  logic [KEY_MID_W-1:0] pool_mid[8];
  logic [KEY_LO_W-1:0]  pool_lo[8];
  int item_total = 0;

  task automatic push_item(kind_e k, int t, int key, bit ok, bit drain);
    sched_item_t it;
    it.kind = k;
    it.txn = t[TXN_W-1:0];
    it.hi = pool_hi[key];
    it.mid = pool_mid[key];
    it.lo = pool_lo[key];
    it.ok = ok;
    it.drain = drain;
    pending_items = {pending_items, it};
    item_total++;
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || start || expected_events.size() != 0);
  endtask

  // finish dispatched transactions, with an occasional start, until the batch completes or the guard runs out
  task automatic retire_batch();
    int pick;
    int guard;
    int live[$];
    guard = 0;
    while (in_flight != 0 && guard < 300) begin
      guard++;
      live.delete();
      for (int i = 0; i < NTXN; i++) if (running[i]) live = {live, i};
      pick = live.size() != 0 ? live[$urandom_range(0, live.size()-1)] : $urandom_range(0, 63);
      if ($urandom_range(0, 9) == 0)
        push_item(KIND_START, $urandom_range(0, 63), $urandom_range(0, 7), 0, 0);
      push_item(KIND_FINISH, pick, $urandom_range(0, 7), $urandom_range(0, 9) != 0,
                $urandom_range(0, 5) == 0);
      settle();
    end
  endtask

  sched_item_t raw;
  int t;

  initial begin
    pool_hi[0] = '1; pool_mid[0] = '1; pool_lo[0] = '1;
    pool_hi[1] = '0; pool_mid[1] = '0; pool_lo[1] = '0;
    for (int i = 2; i < 8; i++) begin
      pool_hi[i] = $urandom;
      pool_mid[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
    end
    clear_schedule();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty start, idle finish, edges, same owner, out-of-order touch
    push_item(KIND_START, 0, 0, 0, 0);
    push_item(KIND_FINISH, 5, 0, 1, 0);
    push_item(KIND_TOUCH, 0, 0, 0, 0);
    push_item(KIND_TOUCH, 1, 0, 0, 0);
    push_item(KIND_TOUCH, 1, 0, 0, 0);
    push_item(KIND_TOUCH, 2, 1, 0, 0);
    push_item(KIND_TOUCH, 63, 1, 0, 0);
    push_item(KIND_TOUCH, 3, 1, 0, 0);
    push_item(KIND_TOUCH, 4, 2, 1, 0);
    push_item(KIND_START, 0, 0, 0, 0);
    push_item(KIND_START, 0, 0, 0, 0);
    push_item(KIND_FINISH, 40, 3, 1, 0);
    push_item(KIND_FINISH, 0, 0, 1, 1);
    push_item(KIND_FINISH, 2, 0, 0, 0);
    settle();
    retire_batch();
    push_item(KIND_START, 0, 0, 0, 1);
    settle();
    retire_batch();
    push_item(KIND_FINISH, 9, 0, 1, 0);

    // random batches
    while (item_total < 110) begin
      push_item(KIND_CLEAR, 0, 0, 0, $urandom_range(0, 1));
      t = 0;
      for (int i = $urandom_range(2, 12); i > 0; i--) begin
        case ($urandom_range(0, 9))
          0: t = $urandom_range(0, 63);
          1: t = 63;
          default: if (t < 63) t = t + $urandom_range(0, 2);
        endcase
        if (t > 63) t = 63;
        if ($urandom_range(0, 4) == 0) begin
          raw.kind = KIND_TOUCH;
          raw.txn = t[TXN_W-1:0];
          raw.hi = $urandom;
          raw.mid = {$urandom, $urandom};
          raw.lo = {$urandom, $urandom};
          raw.ok = $urandom_range(0, 1);
          raw.drain = 0;
          pending_items = {pending_items, raw};
          item_total++;
        end else begin
          push_item(KIND_TOUCH, t, $urandom_range(0, 7), $urandom_range(0, 1), 0);
        end
      end
      if ($urandom_range(0, 5) == 0)
        push_item(kind_e'($urandom_range(0, 2)), $urandom_range(0, 63),
                  $urandom_range(0, 7), $urandom_range(0, 1), 0);
      push_item(KIND_START, $urandom_range(0, 63), 0, 0, 0);
      settle();
      retire_batch();
      if ($urandom_range(0, 2) == 0) begin
        push_item(KIND_START, 0, 0, 0, 0);
        settle();
        retire_batch();
      end
    end

    settle();
    repeat (4000) @(posedge clk_i);
    if (!failed && expected_events.size() == 0) begin
      $display("** txn_address_dependency_scheduler_core: PASSED **");
    end else begin
      $display("** txn_address_dependency_scheduler_core: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
src/tads_pkg.sv
src/tads_ram.sv
src/txn_address_dependency_scheduler_core.sv
src/tads_checker.sv
test/txn_address_dependency_scheduler_core_test.sv
